// File: src/gpioi_pkg.sv
`timescale 1ns / 1ps
// gpioi_pkg: shared types and constants for the gpio port with interrupts
// used by gpioi_pin_lane, gpioi_out_queue and gpio_port_with_interrupts_core
package gpioi_pkg;

   localparam int PIN_COUNT = 32;
   localparam int WORD_W = 32;
   localparam int ICR_PINS = 16;
   localparam logic [WORD_W-1:0] PIN_MASK = WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      SEL_DATA   = 3'd0,
      SEL_DIR    = 3'd1,
      SEL_ICR_LO = 3'd2,
      SEL_ICR_HI = 3'd3,
      SEL_MASK   = 3'd4,
      SEL_STATUS = 3'd5,
      SEL_EDGE   = 3'd6
   } reg_sel_type;

   typedef enum logic [1:0] {
      ICR_LOW     = 2'd0,
      ICR_HIGH    = 2'd1,
      ICR_RISING  = 2'd2,
      ICR_FALLING = 2'd3
   } icr_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic [WORD_W-1:0] pad_out;
      logic [WORD_W-1:0] pad_drive_enable;
      logic              irq;
   } rsp_type;

endpackage

// File: src/gpioi_pin_lane.sv
`timescale 1ns / 1ps
// gpioi_pin_lane: interrupt condition detector for one pin
// depends on gpioi_pkg
module gpioi_pin_lane (
   input  logic       pad_now,
   input  logic       pad_last,
   input  logic [1:0] icr_code,
   input  logic       any_edge,
   output logic       fire
);
   import gpioi_pkg::*;

   always_comb begin
      if (any_edge) begin
         fire = pad_now ^ pad_last;
      end else begin
         case (icr_type'(icr_code))
            ICR_LOW:     fire = ~pad_now;
            ICR_HIGH:    fire = pad_now;
            ICR_RISING:  fire = pad_now & ~pad_last;
            ICR_FALLING: fire = ~pad_now & pad_last;
            default:     fire = 1'b0;
         endcase
      end
   end

endmodule

// File: src/gpioi_out_queue.sv
`timescale 1ns / 1ps
// gpioi_out_queue: two-entry result queue parting the request and response sides
// depends on gpioi_pkg
module gpioi_out_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gpioi_pkg::rsp_type push_data,
   output logic              can_push,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gpioi_pkg::rsp_type rsp_data
);
   import gpioi_pkg::*;

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign can_push  = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/gpio_port_with_interrupts_core.sv
`timescale 1ns / 1ps
// gpio_port_with_interrupts_core: 32-pin gpio port with per-pin interrupt lanes
// depends on gpioi_pkg, gpioi_pin_lane, gpioi_out_queue
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_action, req_reg_select,
//           |           | req_write_data, req_pad_levels
//   rsp     | out       | rsp_valid, rsp_ready, rsp_read_data, rsp_pad_out,
//           |           | rsp_pad_drive_enable, rsp_irq
//
// one item per cycle while req_ready is high; registers and status update at the request transfer
// the result is written into the result queue at its request transfer
// a two-entry result queue keeps req_ready high for one stalled result
// synchronous reset clears all registers and the queue
module gpio_port_with_interrupts_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_action,
   input  logic [2:0]                   req_reg_select,
   input  logic [gpioi_pkg::WORD_W-1:0] req_write_data,
   input  logic [gpioi_pkg::WORD_W-1:0] req_pad_levels,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gpioi_pkg::WORD_W-1:0] rsp_read_data,
   output logic [gpioi_pkg::WORD_W-1:0] rsp_pad_out,
   output logic [gpioi_pkg::WORD_W-1:0] rsp_pad_drive_enable,
   output logic                         rsp_irq
);
   import gpioi_pkg::*;

   logic [WORD_W-1:0] data_ff, data_in;
   logic [WORD_W-1:0] dir_ff, dir_in;
   logic [WORD_W-1:0] icr_lo_ff, icr_lo_in;
   logic [WORD_W-1:0] icr_hi_ff, icr_hi_in;
   logic [WORD_W-1:0] mask_ff, mask_in;
   logic [WORD_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0] edge_sel_ff, edge_sel_in;
   logic [WORD_W-1:0] last_pads_ff, last_pads_in;
   logic [WORD_W-1:0] hits;
   logic [WORD_W-1:0] read_word;
   logic              accept;
   rsp_type           result;
   rsp_type           rsp_data;

   assign accept = req_valid & req_ready;

   // per-pin detection lanes
   for (genvar i = 0; i < WORD_W; i++) begin : g_lane
      if (i < PIN_COUNT) begin : g_pin
         logic [1:0] code;
         if (i < ICR_PINS) begin : g_lo
            assign code = icr_lo_ff[2*i +: 2];
         end else begin : g_hi
            assign code = icr_hi_ff[2*(i-ICR_PINS) +: 2];
         end
         gpioi_pin_lane u_lane (
            .pad_now  (req_pad_levels[i]),
            .pad_last (last_pads_ff[i]),
            .icr_code (code),
            .any_edge (edge_sel_ff[i]),
            .fire     (hits[i])
         );
      end else begin : g_absent
         assign hits[i] = 1'b0;
      end
   end

   always_comb begin
      case (reg_sel_type'(req_reg_select))
         SEL_DATA:   read_word = (data_ff & dir_ff) | (req_pad_levels & ~dir_ff & PIN_MASK);
         SEL_DIR:    read_word = dir_ff;
         SEL_ICR_LO: read_word = icr_lo_ff;
         SEL_ICR_HI: read_word = icr_hi_ff;
         SEL_MASK:   read_word = mask_ff;
         SEL_STATUS: read_word = status_ff;
         SEL_EDGE:   read_word = edge_sel_ff;
         default:    read_word = '0;
      endcase
   end

   // register updates and merge of lane hits into status
   always_comb begin
      data_in      = data_ff;
      dir_in       = dir_ff;
      icr_lo_in    = icr_lo_ff;
      icr_hi_in    = icr_hi_ff;
      mask_in      = mask_ff;
      status_in    = status_ff;
      edge_sel_in  = edge_sel_ff;
      last_pads_in = last_pads_ff;
      result.read_data = '0;
      case (action_type'(req_action))
         ACT_READ: begin
            result.read_data = read_word;
         end
         ACT_WRITE: begin
            case (reg_sel_type'(req_reg_select))
               SEL_DATA:   data_in     = req_write_data & PIN_MASK;
               SEL_DIR:    dir_in      = req_write_data & PIN_MASK;
               SEL_ICR_LO: icr_lo_in   = req_write_data;
               SEL_ICR_HI: icr_hi_in   = req_write_data;
               SEL_MASK:   mask_in     = req_write_data & PIN_MASK;
               SEL_STATUS: status_in   = status_ff & ~req_write_data;
               SEL_EDGE:   edge_sel_in = req_write_data & PIN_MASK;
               default:    ;
            endcase
         end
         ACT_TICK: begin
            status_in    = status_ff | (hits & PIN_MASK);
            last_pads_in = req_pad_levels;
         end
         default: ;
      endcase
      result.pad_out          = data_in;
      result.pad_drive_enable = dir_in;
      result.irq              = |(status_in & mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff      <= '0;
         dir_ff       <= '0;
         icr_lo_ff    <= '0;
         icr_hi_ff    <= '0;
         mask_ff      <= '0;
         status_ff    <= '0;
         edge_sel_ff  <= '0;
         last_pads_ff <= '0;
      end else if (accept) begin
         data_ff      <= data_in;
         dir_ff       <= dir_in;
         icr_lo_ff    <= icr_lo_in;
         icr_hi_ff    <= icr_hi_in;
         mask_ff      <= mask_in;
         status_ff    <= status_in;
         edge_sel_ff  <= edge_sel_in;
         last_pads_ff <= last_pads_in;
      end
   end

   gpioi_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .can_push  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_read_data        = rsp_data.read_data;
   assign rsp_pad_out          = rsp_data.pad_out;
   assign rsp_pad_drive_enable = rsp_data.pad_drive_enable;
   assign rsp_irq              = rsp_data.irq;

endmodule

// File: bench/gpio_port_with_interrupts_core_tb.sv
`timescale 1ns / 1ps
// gpio_port_with_interrupts_core_tb: self-checking bench for the 32-pin gpio port
// drives register reads, writes, pad ticks and unused actions, predicts every result and compares
// depends on gpioi_pkg and gpio_port_with_interrupts_core
module gpio_port_with_interrupts_core_tb;
   import gpioi_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [2:0] SEL_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 250;
   localparam int ITEMS_PER_PHASE = 330;
   localparam int MAX_PRINTED = 40;

   typedef struct packed {
      logic [1:0]        action;
      logic [2:0]        sel;
      logic [WORD_W-1:0] wdata;
      logic [WORD_W-1:0] pads;
   } access_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_action = '0;
   logic [2:0] req_reg_select = '0;
   logic [WORD_W-1:0] req_write_data = '0;
   logic [WORD_W-1:0] req_pad_levels = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_read_data;
   logic [WORD_W-1:0] rsp_pad_out;
   logic [WORD_W-1:0] rsp_pad_drive_enable;
   logic rsp_irq;

   // shadow copy of the port registers
   logic [WORD_W-1:0] shadow_dr = '0;
   logic [WORD_W-1:0] shadow_dir = '0;
   logic [WORD_W-1:0] shadow_icr_lo = '0;
   logic [WORD_W-1:0] shadow_icr_hi = '0;
   logic [WORD_W-1:0] shadow_imr = '0;
   logic [WORD_W-1:0] shadow_isr = '0;
   logic [WORD_W-1:0] shadow_edge = '0;
   logic [WORD_W-1:0] shadow_prev_pads = '0;

   access_type pending_accesses[$];
   rsp_type port_views_due[$];
   access_type offered;
   logic [WORD_W-1:0] walk_pads = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int error_count = 0;
   int cycle_count = 0;
   int read_count = 0;
   int write_count = 0;
   int tick_count = 0;
   int other_count = 0;
   int irq_results = 0;
   int input_stalls = 0;

   gpio_port_with_interrupts_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_reg_select(req_reg_select),
      .req_write_data(req_write_data),
      .req_pad_levels(req_pad_levels),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_pad_out(rsp_pad_out),
      .rsp_pad_drive_enable(rsp_pad_drive_enable),
      .rsp_irq(rsp_irq)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (error_count < MAX_PRINTED)
         $display("mismatch at cycle %0d: %s expected %h got %h", cycle_count, what, want, got);
      error_count++;
   endtask

   function automatic rsp_type next_port_view(access_type a);
      rsp_type v;
      logic [WORD_W-1:0] hits;
      logic [WORD_W-1:0] icr_word;
      logic [1:0] code;
      logic now_lvl;
      logic prev_lvl;
      logic fire;
      v = '0;
      hits = '0;
      case (a.action)
         ACT_READ: begin
            case (a.sel)
               SEL_DATA:
                  v.read_data = (shadow_dr & shadow_dir) | (a.pads & ~shadow_dir & PIN_MASK);
               SEL_DIR:    v.read_data = shadow_dir;
               SEL_ICR_LO: v.read_data = shadow_icr_lo;
               SEL_ICR_HI: v.read_data = shadow_icr_hi;
               SEL_MASK:   v.read_data = shadow_imr;
               SEL_STATUS: v.read_data = shadow_isr;
               SEL_EDGE:   v.read_data = shadow_edge;
               default:    v.read_data = '0;
            endcase
         end
         ACT_WRITE: begin
            case (a.sel)
               SEL_DATA:   shadow_dr = a.wdata & PIN_MASK;
               SEL_DIR:    shadow_dir = a.wdata & PIN_MASK;
               SEL_ICR_LO: shadow_icr_lo = a.wdata;
               SEL_ICR_HI: shadow_icr_hi = a.wdata;
               SEL_MASK:   shadow_imr = a.wdata & PIN_MASK;
               SEL_STATUS: shadow_isr = shadow_isr & ~a.wdata;
               SEL_EDGE:   shadow_edge = a.wdata & PIN_MASK;
               default:    ;
            endcase
         end
         ACT_TICK: begin
            for (int i = 0; i < WORD_W; i++) begin
               now_lvl = a.pads[i];
               prev_lvl = shadow_prev_pads[i];
               icr_word = (i < ICR_PINS) ? shadow_icr_lo : shadow_icr_hi;
               code = icr_word[2*(i % ICR_PINS) +: 2];
               if (shadow_edge[i]) begin
                  fire = now_lvl != prev_lvl;
               end else begin
                  case (icr_type'(code))
                     ICR_LOW:     fire = !now_lvl;
                     ICR_HIGH:    fire = now_lvl;
                     ICR_RISING:  fire = now_lvl && !prev_lvl;
                     default:     fire = !now_lvl && prev_lvl;
                  endcase
               end
               hits[i] = fire;
            end
            shadow_isr = shadow_isr | (hits & PIN_MASK);
            shadow_prev_pads = a.pads;
         end
         default: ;
      endcase
      v.pad_out = shadow_dr;
      v.pad_drive_enable = shadow_dir;
      v.irq = |(shadow_isr & shadow_imr);
      return v;
   endfunction

   task automatic add_access(logic [1:0] act, logic [2:0] sel, logic [WORD_W-1:0] wdata,
                             logic [WORD_W-1:0] pads);
      access_type a;
      a.action = act;
      a.sel = sel;
      a.wdata = wdata;
      a.pads = pads;
      pending_accesses.push_back(a);
   endtask

   function automatic logic [2:0] random_sel();
      if ($urandom_range(19, 0) == 0)
         return SEL_UNUSED;
      return 3'($urandom_range(6, 0));
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      int pick;
      pick = $urandom_range(7, 0);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return $urandom;
   endfunction

   task automatic add_random_accesses(int count);
      int r;
      logic [2:0] sel;
      logic [WORD_W-1:0] w;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99, 0);
         if (r < 2) begin
            add_access(ACT_UNUSED, 3'($urandom_range(7, 0)), $urandom, $urandom);
         end else if (r < 32) begin
            add_access(ACT_READ, random_sel(), $urandom, $urandom);
         end else if (r < 65) begin
            sel = random_sel();
            w = (sel == SEL_STATUS && $urandom_range(1, 0)) ? ($urandom & $urandom) : random_word();
            add_access(ACT_WRITE, sel, w, $urandom);
         end else begin
            // mostly small changes of the pin levels so edges stay sparse
            case ($urandom_range(7, 0))
               0: walk_pads = $urandom;
               1: walk_pads = '0;
               2: walk_pads = '1;
               default: walk_pads = walk_pads ^ ($urandom & $urandom & $urandom);
            endcase
            add_access(ACT_TICK, random_sel(), $urandom, walk_pads);
         end
      end
   endtask

   task automatic wait_for_drain();
      do @(negedge clock);
      while (pending_accesses.size() > 0 || req_valid || port_views_due.size() > 0);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_ready)
            input_stalls++;
         if (req_valid && req_ready) begin
            port_views_due.push_back(next_port_view(offered));
            case (offered.action)
               ACT_READ:  read_count++;
               ACT_WRITE: write_count++;
               ACT_TICK:  tick_count++;
               default:   other_count++;
            endcase
         end
         if (!req_valid || req_ready) begin
            if (pending_accesses.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               offered = pending_accesses.pop_front();
               req_valid <= 1'b1;
               req_action <= offered.action;
               req_reg_select <= offered.sel;
               req_write_data <= offered.wdata;
               req_pad_levels <= offered.pads;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver hold-off counter
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_left <= HOLD_CYCLES;
         hold_served <= hold_requests;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (port_views_due.size() == 0) begin
               report_mismatch("result with nothing pending, read_data", '0, rsp_read_data);
            end else begin
               want = port_views_due.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", want.read_data, rsp_read_data);
               if (rsp_pad_out !== want.pad_out)
                  report_mismatch("pad_out", want.pad_out, rsp_pad_out);
               if (rsp_pad_drive_enable !== want.pad_drive_enable)
                  report_mismatch("pad_drive_enable", want.pad_drive_enable, rsp_pad_drive_enable);
               if (rsp_irq !== want.irq)
                  report_mismatch("irq", WORD_W'(want.irq), WORD_W'(rsp_irq));
               if (rsp_irq === 1'b1)
                  irq_results++;
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", port_views_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 18;
      recv_idle_pct = 68;

      // directed: edge and level detection, clears, any-edge, data read mix
      add_access(ACT_WRITE, SEL_ICR_LO, 32'hAAAA_AAAA, $urandom);
      add_access(ACT_WRITE, SEL_ICR_HI, 32'hFFFF_FFFF, $urandom);
      add_access(ACT_WRITE, SEL_MASK, 32'hFFFF_FFFF, $urandom);
      add_access(ACT_TICK, SEL_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_access(ACT_READ, SEL_STATUS, 32'hFFFF_FFFF, '0);
      add_access(ACT_TICK, SEL_DATA, 32'hFFFF_FFFF, 32'h0000_0000);
      add_access(ACT_READ, SEL_STATUS, '0, 32'hFFFF_FFFF);
      add_access(ACT_WRITE, SEL_STATUS, 32'hFFFF_FFFF, '0);
      add_access(ACT_WRITE, SEL_ICR_LO, 32'h0000_0000, '0);
      add_access(ACT_WRITE, SEL_ICR_HI, 32'h5555_5555, '0);
      add_access(ACT_TICK, SEL_DATA, '0, 32'hFFFF_0000);
      add_access(ACT_WRITE, SEL_STATUS, 32'hFFFF_FFFF, '0);
      add_access(ACT_TICK, SEL_DATA, '0, 32'hFFFF_0000);
      add_access(ACT_READ, SEL_STATUS, '0, '0);
      add_access(ACT_WRITE, SEL_EDGE, 32'hFFFF_FFFF, '0);
      add_access(ACT_TICK, SEL_DATA, '0, 32'h0000_FFFF);
      add_access(ACT_WRITE, SEL_DIR, 32'hF0F0_F0F0, '0);
      add_access(ACT_WRITE, SEL_DATA, 32'hFFFF_FFFF, '0);
      add_access(ACT_READ, SEL_DATA, '0, 32'h1234_5678);
      add_access(ACT_WRITE, SEL_UNUSED, 32'hFFFF_FFFF, '0);
      add_access(ACT_READ, SEL_UNUSED, '0, '1);
      add_access(ACT_UNUSED, SEL_STATUS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_access(ACT_READ, SEL_DIR, '0, '0);
      add_access(ACT_READ, SEL_EDGE, '0, '0);
      add_access(ACT_WRITE, SEL_MASK, 32'h0000_0000, '0);
      add_random_accesses(ITEMS_PER_PHASE);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait_for_drain();

      send_idle_pct = 68;
      recv_idle_pct = 18;
      add_random_accesses(ITEMS_PER_PHASE);
      wait_for_drain();

      // no idling; one long receiver hold-off backs up the port
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_accesses(ITEMS_PER_PHASE);
      @(negedge clock);
      hold_requests++;
      wait_for_drain();

      repeat (10) @(posedge clock);
      if (port_views_due.size() != 0)
         report_mismatch("results never delivered, count", '0, port_views_due.size());
      $display("covered %0d reads, %0d writes, %0d pad ticks, %0d unused actions",
               read_count, write_count, tick_count, other_count);
      $display("%0d results with irq; input held off %0d cycles under backpressure, %0d errors",
               irq_results, input_stalls, error_count);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: files.f
src/gpioi_pkg.sv
src/gpioi_pin_lane.sv
src/gpioi_out_queue.sv
src/gpio_port_with_interrupts_core.sv
bench/gpio_port_with_interrupts_core_tb.sv
